### hw/rtl/ebyed_pkg.sv
// Shared types, constants and word conversion functions for the EBYE block word decoder.
`timescale 1ns / 1ps
`default_nettype none
package ebyed_pkg;

    typedef enum logic [11:0] {
        PH_SYNC_A   = 12'b0000_0000_0001,
        PH_SYNC_B   = 12'b0000_0000_0010,
        PH_TAG_A    = 12'b0000_0000_0100,
        PH_TAG_B    = 12'b0000_0000_1000,
        PH_HEADER   = 12'b0000_0001_0000,
        PH_BODY     = 12'b0000_0010_0000,
        PH_MARK_VAL = 12'b0000_0100_0000,
        PH_DATA_VAL = 12'b0000_1000_0000,
        PH_EXT_GRP  = 12'b0001_0000_0000,
        PH_EXT_MIN  = 12'b0010_0000_0000,
        PH_EXT_MAX  = 12'b0100_0000_0000,
        PH_SKIP     = 12'b1000_0000_0000
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HIT    = 2'd0,
        KIND_EVENT  = 2'd1,
        KIND_END    = 2'd2,
        KIND_BADMRK = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CTRL_DATA   = 2'd0,
        CTRL_GROUP  = 2'd1,
        CTRL_EXTGRP = 2'd2,
        CTRL_MARKER = 2'd3
    } t_ctrl;

    localparam logic [15:0] TAG_EB = 16'h4245;
    localparam logic [15:0] TAG_YE = 16'h4559;
    localparam logic [15:0] TAG_DA = 16'h4144;
    localparam logic [15:0] TAG_TA = 16'h4154;

    localparam logic [2:0] HDR_SWAP_IDX = 3'd5;
    localparam logic [2:0] HDR_LAST_IDX = 3'd7;
    localparam logic [5:0] MARK_HI      = 6'h3f;
    localparam logic [7:0] MARK_LO      = 8'hff;

    function automatic logic [15:0] rev16(input logic [15:0] v);
        logic [15:0] r;
        for (int i = 0; i < 16; i++) begin
            r[15 - i] = v[i];
        end
        return r;
    endfunction

    function automatic logic [15:0] conv_word(input logic [15:0] w, input logic swap);
        logic [15:0] res;
        res = swap ? rev16({w[7:0], w[15:8]}) : w;
        return res;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/ebye_block_word_decoder_top.sv
// Top level of the EBYE block word decoder: input register, phase logic, result register.
// The result register loads a result when the word that completes it is processed.
// Throughput: one word per cycle unless stalled; the phase logic updates once per word.
// The input register is held only while the result register is full and stalled.
// Reset (synchronous, active low) returns to sync search, clearing all but data words.
`timescale 1ns / 1ps
`default_nettype none
module ebye_block_word_decoder_top
    import ebyed_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [15:0] i_raw_word,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [1:0]  o_kind,
    output logic [15:0] o_hit_address,
    output logic [15:0] o_hit_value
);

    logic        r_in_vld;
    logic [15:0] r_in_word;
    logic        r_out_vld;
    logic [1:0]  r_kind;
    logic [15:0] r_addr;
    logic [15:0] r_value;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_hdr_idx, n_hdr_idx;
    logic        r_data_swap, n_data_swap;
    logic [15:0] r_held, n_held;
    logic        r_tag_seen, n_tag_seen;
    logic [15:0] r_skip, n_skip;
    logic [15:0] r_range_low, n_range_low;

    logic        proc;
    logic        res_vld;
    logic [1:0]  res_kind;
    logic [15:0] res_addr;
    logic [15:0] res_value;
    logic [15:0] cw;
    logic [15:0] held_rev;
    logic [15:0] skip_dec;

    assign proc    = r_in_vld && (!r_out_vld || !i_stall);
    assign o_stall = r_in_vld && !proc;
    assign o_valid = r_out_vld;
    assign o_kind  = r_kind;
    assign o_hit_address = r_addr;
    assign o_hit_value   = r_value;

    assign cw       = conv_word(r_in_word, r_data_swap);
    assign held_rev = rev16(r_held);
    assign skip_dec = r_skip - 16'd1;

    always_comb begin
        n_phase     = r_phase;
        n_hdr_idx   = r_hdr_idx;
        n_data_swap = r_data_swap;
        n_held      = r_held;
        n_tag_seen  = r_tag_seen;
        n_skip      = r_skip;
        n_range_low = r_range_low;
        res_vld     = 1'b0;
        res_kind    = KIND_HIT;
        res_addr    = '0;
        res_value   = '0;
        unique case (r_phase)
            PH_SYNC_A: begin
                n_tag_seen = (r_in_word == TAG_EB);
                n_phase    = PH_SYNC_B;
            end
            PH_SYNC_B: begin
                n_phase    = (r_tag_seen && r_in_word == TAG_YE) ? PH_TAG_A : PH_SYNC_A;
                n_tag_seen = 1'b0;
            end
            PH_TAG_A: begin
                n_tag_seen = (r_in_word == TAG_DA);
                n_phase    = PH_TAG_B;
            end
            PH_TAG_B: begin
                if (r_tag_seen && r_in_word == TAG_TA) begin
                    n_phase   = PH_HEADER;
                    n_hdr_idx = '0;
                end else begin
                    n_phase = PH_SYNC_A;
                end
                n_tag_seen = 1'b0;
            end
            PH_HEADER: begin
                if (r_hdr_idx == HDR_SWAP_IDX) begin
                    n_data_swap = (r_in_word != '0);
                end
                if (r_hdr_idx == HDR_LAST_IDX) begin
                    n_phase = PH_BODY;
                end
                n_hdr_idx = r_hdr_idx + 3'd1;
            end
            PH_BODY: begin
                n_held = cw;
                case (t_ctrl'(cw[1:0]))
                    CTRL_DATA: n_phase = PH_DATA_VAL;
                    CTRL_GROUP: begin
                        n_skip  = {10'd0, cw[13:8]};
                        n_phase = (cw[13:8] != '0) ? PH_SKIP : PH_BODY;
                    end
                    CTRL_EXTGRP: begin
                        n_skip  = {2'd0, cw[13:0]};
                        n_phase = PH_EXT_GRP;
                    end
                    default: n_phase = PH_MARK_VAL;
                endcase
            end
            PH_MARK_VAL: begin
                res_vld = 1'b1;
                if (r_held[13:8] == MARK_HI && r_held[7:0] == MARK_LO) begin
                    if (cw == '0) begin
                        res_kind = KIND_END;
                        n_phase  = PH_SYNC_A;
                    end else begin
                        res_kind = KIND_EVENT;
                        n_phase  = PH_BODY;
                    end
                end else begin
                    res_kind = KIND_BADMRK;
                    n_phase  = PH_BODY;
                end
            end
            PH_DATA_VAL: begin
                res_vld   = 1'b1;
                res_kind  = KIND_HIT;
                res_addr  = {3'd0, held_rev[7:0], 5'd0} - 16'd32 + {10'd0, held_rev[13:8]};
                res_value = rev16(cw);
                n_phase   = PH_BODY;
            end
            PH_EXT_GRP: begin
                n_phase = (r_skip != '0) ? PH_SKIP : PH_EXT_MIN;
            end
            PH_EXT_MIN: begin
                n_range_low = cw;
                n_phase     = PH_EXT_MAX;
            end
            PH_EXT_MAX: begin
                n_skip  = cw - r_range_low;
                n_phase = (cw != r_range_low) ? PH_SKIP : PH_BODY;
            end
            PH_SKIP: begin
                n_skip = skip_dec;
                if (skip_dec == '0) begin
                    n_phase = PH_BODY;
                end
            end
            default: begin
                n_phase = PH_SYNC_A;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_phase     <= PH_SYNC_A;
            r_hdr_idx   <= '0;
            r_data_swap <= 1'b0;
            r_held      <= '0;
            r_tag_seen  <= 1'b0;
            r_skip      <= '0;
            r_range_low <= '0;
        end else begin
            if (!o_stall) begin
                r_in_vld <= i_valid;
            end
            if (proc) begin
                r_out_vld   <= res_vld;
                r_phase     <= n_phase;
                r_hdr_idx   <= n_hdr_idx;
                r_data_swap <= n_data_swap;
                r_held      <= n_held;
                r_tag_seen  <= n_tag_seen;
                r_skip      <= n_skip;
                r_range_low <= n_range_low;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_word <= i_raw_word;
        end
        if (proc && res_vld) begin
            r_kind  <= res_kind;
            r_addr  <= res_addr;
            r_value <= res_value;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/ebyed_checker.sv
// Port-level checker for the EBYE block word decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ebyed_checker
    import ebyed_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_valid,
    input wire        o_stall,
    input wire [15:0] i_raw_word,
    input wire        o_valid,
    input wire        i_stall,
    input wire [1:0]  o_kind,
    input wire [15:0] o_hit_address,
    input wire [15:0] o_hit_value
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_hit_address)
            && $stable(o_hit_value))
        else $error("stalled result changed");

    // stalled request holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_raw_word))
        else $error("stalled request changed");

    a_nonhit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_HIT |-> o_hit_address == '0 && o_hit_value == '0)
        else $error("non-hit result carries hit fields");

    // input backs up only behind a full, stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output back-pressure");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("reset did not clear handshake");

endmodule

bind ebye_block_word_decoder_top ebyed_checker u_ebyed_checker (.*);
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the EBYE block word decoder: directed and random word streams.
`timescale 1ns / 1ps
module tb_top;
    import ebyed_pkg::*;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] address;
        logic [15:0] value;
    } t_decode;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic [15:0] i_raw_word = 16'h0000;
    logic        i_stall    = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic [15:0] o_hit_address;
    logic [15:0] o_hit_value;

    // decoder mirror
    t_phase      m_phase    = PH_SYNC_A;
    logic [2:0]  m_hdr_idx  = 3'd0;
    logic        m_swap     = 1'b0;
    logic [15:0] m_held     = 16'h0000;
    logic        m_tag_seen = 1'b0;
    logic [15:0] m_skip     = 16'h0000;
    logic [15:0] m_low      = 16'h0000;

    t_decode     pending_decodes[$];
    t_decode     head_decode;
    logic        gen_swap       = 1'b0;
    int          words_sent     = 0;
    int          tx_idle_pct    = 0;
    int          rx_idle_pct    = 0;
    int          mismatch_count = 0;

    ebye_block_word_decoder_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_raw_word    (i_raw_word),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_hit_address (o_hit_address),
        .o_hit_value   (o_hit_value)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [15:0] flip16(input logic [15:0] v);
        logic [15:0] r;
        for (int i = 0; i < 16; i++) begin
            r[15 - i] = v[i];
        end
        return r;
    endfunction

    function automatic logic [15:0] to_native(input logic [15:0] w);
        return m_swap ? flip16({w[7:0], w[15:8]}) : w;
    endfunction

    // raw file word that converts to c under the swap setting the stream has chosen
    function automatic logic [15:0] raw_of(input logic [15:0] c);
        logic [15:0] f;
        f = flip16(c);
        return gen_swap ? {f[7:0], f[15:8]} : c;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 50) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
    endtask

    task automatic predict_decode(input logic [15:0] w);
        logic [15:0] c;
        logic [15:0] a;
        t_decode     r;
        r = '0;
        case (m_phase)
            PH_SYNC_B: begin
                if (m_tag_seen && w == TAG_YE) m_phase = PH_TAG_A;
                else m_phase = PH_SYNC_A;
                m_tag_seen = 1'b0;
            end
            PH_TAG_A: begin
                m_tag_seen = (w == TAG_DA);
                m_phase    = PH_TAG_B;
            end
            PH_TAG_B: begin
                if (m_tag_seen && w == TAG_TA) begin
                    m_phase   = PH_HEADER;
                    m_hdr_idx = 3'd0;
                end else begin
                    m_phase = PH_SYNC_A;
                end
                m_tag_seen = 1'b0;
            end
            PH_HEADER: begin
                if (m_hdr_idx == HDR_SWAP_IDX) m_swap = (w != 16'h0000);
                if (m_hdr_idx == HDR_LAST_IDX) m_phase = PH_BODY;
                m_hdr_idx = m_hdr_idx + 3'd1;
            end
            PH_BODY: begin
                c      = to_native(w);
                m_held = c;
                case (t_ctrl'(c[1:0]))
                    CTRL_DATA: m_phase = PH_DATA_VAL;
                    CTRL_GROUP: begin
                        m_skip = {10'd0, c[13:8]};
                        if (m_skip != 16'h0000) m_phase = PH_SKIP;
                        else m_phase = PH_BODY;
                    end
                    CTRL_EXTGRP: begin
                        m_skip  = {2'b00, c[13:0]};
                        m_phase = PH_EXT_GRP;
                    end
                    default: m_phase = PH_MARK_VAL;
                endcase
            end
            PH_MARK_VAL: begin
                c = to_native(w);
                if (m_held[13:8] == MARK_HI && m_held[7:0] == MARK_LO) begin
                    if (c == 16'h0000) begin
                        r.kind  = KIND_END;
                        m_phase = PH_SYNC_A;
                    end else begin
                        r.kind  = KIND_EVENT;
                        m_phase = PH_BODY;
                    end
                end else begin
                    r.kind  = KIND_BADMRK;
                    m_phase = PH_BODY;
                end
                pending_decodes = {pending_decodes, r};
            end
            PH_DATA_VAL: begin
                a         = flip16(m_held);
                r.kind    = KIND_HIT;
                r.address = ({8'h00, a[7:0]} << 5) - 16'd32 + {10'd0, a[13:8]};
                r.value   = flip16(to_native(w));
                pending_decodes = {pending_decodes, r};
                m_phase = PH_BODY;
            end
            PH_EXT_GRP: begin
                if (m_skip != 16'h0000) m_phase = PH_SKIP;
                else m_phase = PH_EXT_MIN;
            end
            PH_EXT_MIN: begin
                m_low   = to_native(w);
                m_phase = PH_EXT_MAX;
            end
            PH_EXT_MAX: begin
                m_skip = to_native(w) - m_low;
                if (m_skip != 16'h0000) m_phase = PH_SKIP;
                else m_phase = PH_BODY;
            end
            PH_SKIP: begin
                m_skip = m_skip - 16'd1;
                if (m_skip == 16'h0000) m_phase = PH_BODY;
            end
            default: begin
                m_tag_seen = (w == TAG_EB);
                m_phase    = PH_SYNC_B;
            end
        endcase
    endtask

    task automatic send_word(input logic [15:0] w);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_raw_word <= w;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        predict_decode(w);
        words_sent++;
    endtask

    task automatic send_native(input logic [15:0] c);
        send_word(raw_of(c));
    endtask

    task automatic hold_until_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_decodes.size() != 0);
    endtask

    task automatic send_tag();
        send_word(TAG_EB);
        send_word(TAG_YE);
        send_word(TAG_DA);
        send_word(TAG_TA);
    endtask

    // result side: check each accepted result, then choose the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            if (pending_decodes.size() == 0) begin
                report_mismatch($sformatf("unexpected result, kind %0d", o_kind));
            end else begin
                head_decode = pending_decodes.pop_front();
                if (o_kind !== head_decode.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d",
                        o_kind, head_decode.kind));
                if (o_hit_address !== head_decode.address)
                    report_mismatch($sformatf("address %h, expected %h",
                        o_hit_address, head_decode.address));
                if (o_hit_value !== head_decode.value)
                    report_mismatch($sformatf("value %h, expected %h",
                        o_hit_value, head_decode.value));
            end
        end
        i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    task automatic test_directed_block();
        tx_idle_pct = 22;
        rx_idle_pct = 71;
        send_tag();
        for (int h = 0; h < 8; h++) begin
            send_word((h == 5 || h == 7) ? 16'hFFFF : 16'h0000);
        end
        gen_swap = 1'b1;
        // group 0, item 63: the subtraction wraps below zero before the item is added
        send_native(16'h00FC);
        send_word(16'hFFFF);
        // largest group and item
        send_native(16'hFFFC);
        send_word(16'h0000);
        // empty group, then extended group of two payload words
        send_native(16'h0001);
        send_native(16'h0002);
        send_word(16'h0000);
        send_word(16'hFFFF);
        send_word(16'h0000);
        send_native(16'h0003);
        send_word(16'h1234);
        send_native(16'hFFFF);
        send_native(16'h8001);
        send_native(16'h3FFF);
        send_native(16'h0000);
        hold_until_drained();
    endtask

    task automatic test_tag_mismatch();
        send_word(TAG_EB);
        send_word(TAG_YE);
        send_word(TAG_DA);
        send_word(16'h4155);
        send_word(TAG_EB);
        send_word(16'h4558);
        hold_until_drained();
    endtask

    task automatic test_random_blocks(input int n_words, input int tx_pct, input int rx_pct);
        int          stop_at;
        int          pick;
        logic [15:0] c;
        logic [15:0] v;
        logic [5:0]  gcount;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        stop_at     = words_sent + n_words;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat (2 * $urandom_range(1, 3)) send_word(16'($urandom));
            end
            if ($urandom_range(0, 9) == 0) begin
                send_word(TAG_EB);
                send_word(TAG_YE);
                if ($urandom_range(0, 1) == 0) begin
                    send_word(TAG_DA);
                    send_word(16'($urandom));
                end else begin
                    send_word(16'($urandom));
                    send_word(TAG_TA);
                end
            end
            send_tag();
            for (int h = 0; h < 8; h++) begin
                if (h == 5) begin
                    pick = $urandom_range(0, 3);
                    v = (pick < 2) ? 16'h0000 : (pick == 2) ? 16'hFFFF : 16'($urandom);
                    gen_swap = (v != 16'h0000);
                end else begin
                    v = 16'($urandom);
                end
                send_word(v);
            end
            repeat ($urandom_range(1, 15)) begin
                c = 16'($urandom);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        c[1:0] = CTRL_DATA;
                        send_native(c);
                        send_word(16'($urandom));
                    end
                    4, 5: begin
                        gcount = ($urandom_range(0, 9) == 0) ? 6'($urandom)
                                                             : 6'($urandom_range(0, 4));
                        c[13:8] = gcount;
                        c[1:0]  = CTRL_GROUP;
                        send_native(c);
                        repeat (gcount) send_word(16'($urandom));
                    end
                    6: begin
                        c[13:2] = ($urandom_range(0, 99) == 0) ? 12'($urandom_range(0, 63))
                                                               : 12'($urandom_range(0, 3));
                        c[1:0]  = CTRL_EXTGRP;
                        send_native(c);
                        repeat (c[13:0] + 1) send_word(16'($urandom));
                    end
                    7: begin
                        pick   = $urandom_range(0, 2);
                        c[1:0] = CTRL_MARKER;
                        if (pick == 0) c[13:8] = MARK_HI;
                        if (pick == 1) c[7:0] = MARK_LO;
                        if (c[13:0] == 14'h3FFF) c[(pick == 0) ? 4 : 10] = 1'b0;
                        send_native(c);
                        send_word(16'($urandom));
                    end
                    default: begin
                        c[13:0] = 14'h3FFF;
                        send_native(c);
                        do v = 16'($urandom); while (v == 16'h0000);
                        send_native(v);
                    end
                endcase
            end
            // a few blocks run on without their end marker
            if ($urandom_range(0, 19) != 0) begin
                c = 16'($urandom);
                c[13:0] = 14'h3FFF;
                send_native(c);
                send_native(16'h0000);
            end
        end
        hold_until_drained();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_block();
        test_tag_mismatch();
        test_random_blocks(700, 22, 71);
        test_random_blocks(700, 71, 22);
        test_random_blocks(700, 0, 0);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
hw/rtl/ebyed_pkg.sv
hw/rtl/ebye_block_word_decoder_top.sv
hw/rtl/ebyed_checker.sv
tb/tb_top.sv
